>>> rtl/conv_window_gather_core_macros.svh
`ifndef CONV_WINDOW_GATHER_CORE_MACROS_SVH
`define CONV_WINDOW_GATHER_CORE_MACROS_SVH

// Same-cycle implication, off while in reset.
`define CWG_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define CWG_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/cwg_pkg.sv
`default_nettype none

package cwg_pkg;

  localparam int unsigned FILTER_ROWS = 3;
  localparam int unsigned FILTER_COLS = 3;
  localparam int unsigned CHANNELS    = 4;
  localparam int unsigned STORE_DEPTH = 4096;

  localparam int unsigned ELEMS    = FILTER_ROWS * FILTER_COLS * CHANNELS;
  localparam int unsigned STORE_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned FR_W     = (FILTER_ROWS > 1) ? $clog2(FILTER_ROWS) : 1;
  localparam int unsigned FC_W     = (FILTER_COLS > 1) ? $clog2(FILTER_COLS) : 1;
  localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned EL_W     = (ELEMS > 1) ? $clog2(ELEMS) : 1;

  // Field widths.
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned LOAD_AW    = 12;
  localparam int unsigned IMG_W      = 4;
  localparam int unsigned WIN_W      = 8;
  localparam int unsigned ROW_W      = 6;
  localparam int unsigned COL_W      = 20;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned PAD_W      = 4;
  localparam int unsigned STRIDE_W   = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = DIM_W;

  // Internal widths.
  localparam int unsigned SUM_W  = 10;  // padded size, window count
  localparam int unsigned DCNT_W = $clog2(SUM_W);
  localparam int unsigned COR_W  = 15;  // window corner, two's complement
  localparam int unsigned RS_W   = 16;  // image*H + h
  localparam int unsigned PIX_W  = 26;  // pixel index
  localparam int unsigned ADDR_W = 32;  // element address before range check
  localparam int unsigned PH_W   = 14;  // image*outH + window_row
  localparam int unsigned COLP_W = 24;  // full column product

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_HEIGHT = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_PAD_TOP      = 3'd2,
    REG_PAD_BOTTOM   = 3'd3,
    REG_PAD_LEFT     = 3'd4,
    REG_PAD_RIGHT    = 3'd5,
    REG_STRIDE_ROWS  = 3'd6,
    REG_STRIDE_COLS  = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIM,
    ST_BASE,
    ST_COL,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic             pad;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [CH_W-1:0]  ch;
    logic [RS_W-1:0]  rs;
    logic [DIM_W-1:0] w;
  } s1_t;

  typedef struct packed {
    logic             pad;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [CH_W-1:0]  ch;
    logic [PIX_W-1:0] pix;
  } s2_t;

  typedef struct packed {
    logic             pad;
    logic             zero;
    logic             last;
    logic [ROW_W-1:0] row;
  } s3_t;

endpackage

`default_nettype wire

>>> rtl/conv_window_gather_core.sv
// Load beat: written to the image store at the accepting edge, no result, busy stays low.
// Window beat: 10-step stride divider, then setup states DIM, BASE and COL, then one
// element per cycle, with a store read for each that is not padding or out of range.
// Elements pass the s1, s2, s3 and result registers; a new start is taken only after
// the drain, back in idle. Bad request: one result, flagged last, after the COL state.
// Reset sets control and config registers to defaults; store is undefined until loaded.
`default_nettype none
`include "conv_window_gather_core_macros.svh"

module conv_window_gather_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cwg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cwg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               start,
  output logic                               busy,
  input  logic                               mode_i,
  input  logic [cwg_pkg::LOAD_AW-1:0]        load_address_i,
  input  logic [cwg_pkg::VALUE_W-1:0]        load_value_i,
  input  logic [cwg_pkg::IMG_W-1:0]          image_index_i,
  input  logic [cwg_pkg::WIN_W-1:0]          window_row_i,
  input  logic [cwg_pkg::WIN_W-1:0]          window_col_i,
  output logic                               result_strobe_o,
  output logic [cwg_pkg::VALUE_W-1:0]        element_value_o,
  output logic [cwg_pkg::ROW_W-1:0]          row_index_o,
  output logic [cwg_pkg::COL_W-1:0]          column_index_o,
  output logic                               is_padding_o,
  output logic                               bad_request_o,
  output logic                               last_o
);

  // Config registers.
  logic [cwg_pkg::DIM_W-1:0]    img_h_q, img_w_q;
  logic [cwg_pkg::PAD_W-1:0]    pad_top_q, pad_bot_q, pad_left_q, pad_right_q;
  logic [cwg_pkg::STRIDE_W-1:0] stride_r_q, stride_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_h_q     <= cwg_pkg::DIM_W'(8);
      img_w_q     <= cwg_pkg::DIM_W'(8);
      pad_top_q   <= '0;
      pad_bot_q   <= '0;
      pad_left_q  <= '0;
      pad_right_q <= '0;
      stride_r_q  <= cwg_pkg::STRIDE_W'(1);
      stride_c_q  <= cwg_pkg::STRIDE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cwg_pkg::cfg_reg_e'(cfg_idx_i))
        cwg_pkg::REG_IMAGE_HEIGHT: img_h_q     <= cfg_wdata_i[cwg_pkg::DIM_W-1:0];
        cwg_pkg::REG_IMAGE_WIDTH:  img_w_q     <= cfg_wdata_i[cwg_pkg::DIM_W-1:0];
        cwg_pkg::REG_PAD_TOP:      pad_top_q   <= cfg_wdata_i[cwg_pkg::PAD_W-1:0];
        cwg_pkg::REG_PAD_BOTTOM:   pad_bot_q   <= cfg_wdata_i[cwg_pkg::PAD_W-1:0];
        cwg_pkg::REG_PAD_LEFT:     pad_left_q  <= cfg_wdata_i[cwg_pkg::PAD_W-1:0];
        cwg_pkg::REG_PAD_RIGHT:    pad_right_q <= cfg_wdata_i[cwg_pkg::PAD_W-1:0];
        cwg_pkg::REG_STRIDE_ROWS:  stride_r_q  <= cfg_wdata_i[cwg_pkg::STRIDE_W-1:0];
        cwg_pkg::REG_STRIDE_COLS:  stride_c_q  <= cfg_wdata_i[cwg_pkg::STRIDE_W-1:0];
      endcase
    end
  end

  // FSM.
  cwg_pkg::state_e state_q, state_d;
  logic [cwg_pkg::DCNT_W-1:0] divcnt_q;
  logic [cwg_pkg::EL_W-1:0]   elem_q;
  logic bad_q;
  logic s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;

  logic win_accept, load_we, div_step, dim_en, base_en, col_en, run_en, emit_bad;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cwg_pkg::ST_IDLE:  if (start && mode_i) state_d = cwg_pkg::ST_DIV;
      cwg_pkg::ST_DIV:   if (divcnt_q == '0) state_d = cwg_pkg::ST_DIM;
      cwg_pkg::ST_DIM:   state_d = cwg_pkg::ST_BASE;
      cwg_pkg::ST_BASE:  state_d = cwg_pkg::ST_COL;
      cwg_pkg::ST_COL:   state_d = bad_q ? cwg_pkg::ST_IDLE : cwg_pkg::ST_RUN;
      cwg_pkg::ST_RUN: begin
        if (elem_q == cwg_pkg::EL_W'(cwg_pkg::ELEMS - 1)) state_d = cwg_pkg::ST_DRAIN;
      end
      cwg_pkg::ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q && !s3_vld_q) state_d = cwg_pkg::ST_IDLE;
      end
      default:           state_d = cwg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state_q != cwg_pkg::ST_IDLE);
    win_accept = (state_q == cwg_pkg::ST_IDLE) && start && mode_i;
    load_we    = (state_q == cwg_pkg::ST_IDLE) && start && !mode_i;
    div_step   = (state_q == cwg_pkg::ST_DIV);
    dim_en     = (state_q == cwg_pkg::ST_DIM);
    base_en    = (state_q == cwg_pkg::ST_BASE);
    col_en     = (state_q == cwg_pkg::ST_COL);
    run_en     = (state_q == cwg_pkg::ST_RUN);
    emit_bad   = col_en && bad_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cwg_pkg::ST_IDLE;
      divcnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (win_accept) begin
        divcnt_q <= cwg_pkg::DCNT_W'(cwg_pkg::SUM_W - 1);
      end else if (div_step) begin
        divcnt_q <= divcnt_q - cwg_pkg::DCNT_W'(1);
      end
    end
  end

  // Request latch and stride dividers: index 0 is rows, 1 is columns.
  logic [cwg_pkg::IMG_W-1:0]    img_q;
  logic [cwg_pkg::WIN_W-1:0]    wr_q, wc_q;
  logic [cwg_pkg::SUM_W-1:0]    quo_q [2];
  logic [cwg_pkg::STRIDE_W-1:0] rem_q [2];
  logic [cwg_pkg::STRIDE_W-1:0] den_q [2];
  logic                         ge_q  [2];
  logic [cwg_pkg::SUM_W-1:0]    dim_q [2];

  logic [cwg_pkg::SUM_W-1:0]    total_c [2];
  logic [cwg_pkg::SUM_W-1:0]    filt_c  [2];
  logic [cwg_pkg::STRIDE_W-1:0] str_c   [2];
  logic [cwg_pkg::STRIDE_W:0]   shin_c  [2];
  logic                         qbit_c  [2];
  logic [cwg_pkg::SUM_W-1:0]    dimv_c  [2];

  always_comb begin
    total_c[0] = cwg_pkg::SUM_W'(img_h_q) + cwg_pkg::SUM_W'(pad_top_q)
               + cwg_pkg::SUM_W'(pad_bot_q);
    total_c[1] = cwg_pkg::SUM_W'(img_w_q) + cwg_pkg::SUM_W'(pad_left_q)
               + cwg_pkg::SUM_W'(pad_right_q);
    filt_c[0]  = cwg_pkg::SUM_W'(cwg_pkg::FILTER_ROWS);
    filt_c[1]  = cwg_pkg::SUM_W'(cwg_pkg::FILTER_COLS);
    str_c[0]   = (stride_r_q == '0) ? cwg_pkg::STRIDE_W'(1) : stride_r_q;
    str_c[1]   = (stride_c_q == '0) ? cwg_pkg::STRIDE_W'(1) : stride_c_q;
    for (int d = 0; d < 2; d++) begin
      shin_c[d] = {rem_q[d], quo_q[d][cwg_pkg::SUM_W-1]};
      qbit_c[d] = (shin_c[d] >= {1'b0, den_q[d]});
      dimv_c[d] = ge_q[d] ? (quo_q[d] + cwg_pkg::SUM_W'(1)) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_accept) begin
      img_q <= image_index_i;
      wr_q  <= window_row_i;
      wc_q  <= window_col_i;
    end
    for (int d = 0; d < 2; d++) begin
      if (win_accept) begin
        ge_q[d]  <= (total_c[d] >= filt_c[d]);
        quo_q[d] <= (total_c[d] >= filt_c[d]) ? (total_c[d] - filt_c[d]) : '0;
        rem_q[d] <= '0;
        den_q[d] <= str_c[d];
      end else if (div_step) begin
        quo_q[d] <= {quo_q[d][cwg_pkg::SUM_W-2:0], qbit_c[d]};
        rem_q[d] <= qbit_c[d]
                  ? cwg_pkg::STRIDE_W'(shin_c[d] - {1'b0, den_q[d]})
                  : shin_c[d][cwg_pkg::STRIDE_W-1:0];
      end
      if (dim_en) begin
        dim_q[d] <= dimv_c[d];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= 1'b0;
    end else if (dim_en) begin
      bad_q <= (cwg_pkg::SUM_W'(wr_q) >= dimv_c[0]) || (cwg_pkg::SUM_W'(wc_q) >= dimv_c[1]);
    end
  end

  // Window base values.
  logic [cwg_pkg::RS_W-1:0]  img_base_q;
  logic [cwg_pkg::COR_W-1:0] cor_h_q, cor_w_q;
  logic [cwg_pkg::PH_W-1:0]  ph_q;
  logic [cwg_pkg::COL_W-1:0] col_q;
  logic [cwg_pkg::COLP_W-1:0] colp;

  assign colp = cwg_pkg::COLP_W'(ph_q) * cwg_pkg::COLP_W'(dim_q[1])
              + cwg_pkg::COLP_W'(wc_q);

  always_ff @(posedge clk_i) begin
    if (base_en) begin
      img_base_q <= cwg_pkg::RS_W'(img_q) * cwg_pkg::RS_W'(img_h_q);
      cor_h_q    <= cwg_pkg::COR_W'(wr_q) * cwg_pkg::COR_W'(den_q[0])
                  - cwg_pkg::COR_W'(pad_top_q);
      cor_w_q    <= cwg_pkg::COR_W'(wc_q) * cwg_pkg::COR_W'(den_q[1])
                  - cwg_pkg::COR_W'(pad_left_q);
      ph_q       <= cwg_pkg::PH_W'(img_q) * cwg_pkg::PH_W'(dim_q[0])
                  + cwg_pkg::PH_W'(wr_q);
    end
    if (col_en) begin
      col_q <= colp[cwg_pkg::COL_W-1:0];
    end
  end

  // Element sequencer.
  logic [cwg_pkg::FR_W-1:0] fh_q;
  logic [cwg_pkg::FC_W-1:0] fw_q;
  logic [cwg_pkg::CH_W-1:0] ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q   <= '0;
      fw_q   <= '0;
      ch_q   <= '0;
      elem_q <= '0;
    end else if (col_en) begin
      fh_q   <= '0;
      fw_q   <= '0;
      ch_q   <= '0;
      elem_q <= '0;
    end else if (run_en) begin
      elem_q <= elem_q + cwg_pkg::EL_W'(1);
      if (ch_q == cwg_pkg::CH_W'(cwg_pkg::CHANNELS - 1)) begin
        ch_q <= '0;
        if (fw_q == cwg_pkg::FC_W'(cwg_pkg::FILTER_COLS - 1)) begin
          fw_q <= '0;
          fh_q <= fh_q + cwg_pkg::FR_W'(1);
        end else begin
          fw_q <= fw_q + cwg_pkg::FC_W'(1);
        end
      end else begin
        ch_q <= ch_q + cwg_pkg::CH_W'(1);
      end
    end
  end

  // Stage 0: position and padding.
  logic [cwg_pkg::COR_W-1:0] h0, w0;
  cwg_pkg::s1_t s1_d, s1_q;

  always_comb begin
    h0        = cor_h_q + cwg_pkg::COR_W'(fh_q);
    w0        = cor_w_q + cwg_pkg::COR_W'(fw_q);
    s1_d.pad  = h0[cwg_pkg::COR_W-1] || (h0 >= cwg_pkg::COR_W'(img_h_q))
             || w0[cwg_pkg::COR_W-1] || (w0 >= cwg_pkg::COR_W'(img_w_q));
    s1_d.last = (elem_q == cwg_pkg::EL_W'(cwg_pkg::ELEMS - 1));
    s1_d.row  = cwg_pkg::ROW_W'(elem_q);
    s1_d.ch   = ch_q;
    s1_d.rs   = img_base_q + cwg_pkg::RS_W'(h0);
    s1_d.w    = w0[cwg_pkg::DIM_W-1:0];
  end

  // Stage 1: pixel index.
  cwg_pkg::s2_t s2_d, s2_q;

  always_comb begin
    s2_d.pad  = s1_q.pad;
    s2_d.last = s1_q.last;
    s2_d.row  = s1_q.row;
    s2_d.ch   = s1_q.ch;
    s2_d.pix  = cwg_pkg::PIX_W'(s1_q.rs) * cwg_pkg::PIX_W'(img_w_q)
              + cwg_pkg::PIX_W'(s1_q.w);
  end

  // Stage 2: element address, store read.
  logic [cwg_pkg::ADDR_W-1:0] addr2;
  logic oob2, ram_re, ram_we;
  cwg_pkg::s3_t s3_d, s3_q;
  logic [cwg_pkg::VALUE_W-1:0] ram_rdata;

  always_comb begin
    addr2     = cwg_pkg::ADDR_W'(s2_q.pix) * cwg_pkg::ADDR_W'(cwg_pkg::CHANNELS)
              + cwg_pkg::ADDR_W'(s2_q.ch);
    oob2      = (addr2 >= cwg_pkg::ADDR_W'(cwg_pkg::STORE_DEPTH));
    ram_re    = s2_vld_q && !s2_q.pad && !oob2;
    s3_d.pad  = s2_q.pad;
    s3_d.zero = s2_q.pad || oob2;
    s3_d.last = s2_q.last;
    s3_d.row  = s2_q.row;
  end

  assign ram_we = load_we
               && (cwg_pkg::ADDR_W'(load_address_i) < cwg_pkg::ADDR_W'(cwg_pkg::STORE_DEPTH));

  cwg_ram #(
    .WIDTH (cwg_pkg::VALUE_W),
    .DEPTH (cwg_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cwg_pkg::STORE_AW'(load_address_i)),
    .wdata_i (load_value_i),
    .re_i    (ram_re),
    .raddr_i (cwg_pkg::STORE_AW'(addr2)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= run_en;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= emit_bad || s3_vld_q;
    end
  end

  // Result register.
  logic [cwg_pkg::VALUE_W-1:0] out_value_q;
  logic [cwg_pkg::ROW_W-1:0]   out_row_q;
  logic [cwg_pkg::COL_W-1:0]   out_col_q;
  logic out_pad_q, out_bad_q, out_last_q;

  always_ff @(posedge clk_i) begin
    if (emit_bad) begin
      out_value_q <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_pad_q   <= 1'b0;
      out_bad_q   <= 1'b1;
      out_last_q  <= 1'b1;
    end else if (s3_vld_q) begin
      out_value_q <= s3_q.zero ? '0 : ram_rdata;
      out_row_q   <= s3_q.row;
      out_col_q   <= col_q;
      out_pad_q   <= s3_q.pad;
      out_bad_q   <= 1'b0;
      out_last_q  <= s3_q.last;
    end
  end

  assign result_strobe_o = out_vld_q;
  assign element_value_o = out_value_q;
  assign row_index_o     = out_row_q;
  assign column_index_o  = out_col_q;
  assign is_padding_o    = out_pad_q;
  assign bad_request_o   = out_bad_q;
  assign last_o          = out_last_q;

  `CWG_ASSERT_IMP(a_no_store_rw, ram_we, !ram_re, "store read and write in one cycle")
  `CWG_ASSERT_IMP(a_bad_beat, result_strobe_o && bad_request_o, last_o && !is_padding_o && (element_value_o == '0), "bad request beat malformed")
  `CWG_ASSERT_NXT(a_last_gap, result_strobe_o && last_o, !result_strobe_o, "beat right after last")
  `CWG_ASSERT_NXT(a_window_busy, start && !busy && mode_i, busy, "window accepted but not busy")
  `CWG_ASSERT_IMP(a_pipe_busy, s1_vld_q || s2_vld_q || s3_vld_q, busy, "gather pipe active while idle")

endmodule

`default_nettype wire

>>> rtl/cwg_ram.sv
`default_nettype none

module cwg_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
